FILE: design/chfi_pkg.sv
// ----------------------------------------------------------------------------
// chfi_pkg
// Shared types and codes for the chained hash find-or-insert block.
// ----------------------------------------------------------------------------
package chfi_pkg;

  localparam int COORD_BITS = 16;
  localparam int KEY_W      = 2 * COORD_BITS;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] RES_NONE = 3'd0;
  localparam logic [2:0] RES_HIT  = 3'd1;
  localparam logic [2:0] RES_BASE = 3'd2;
  localparam logic [2:0] RES_POOL = 3'd3;
  localparam logic [2:0] RES_FULL = 3'd4;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       rd_link;
    logic       claim_base;
    logic       write_pool;
    logic       link_tail;
    logic       clear;
    logic       res_load;
    logic [2:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hash_done;
    logic       bucket_valid;
    logic       key_match;
    logic       link_zero;
    logic       pool_full;
    logic       out_free;
  } sts_t;

endpackage

FILE: design/chfi_ctrl.sv
// ----------------------------------------------------------------------------
// chfi_ctrl
// Sequencer for hashing, chain walk, claim, link-in and clear of one item.
// ----------------------------------------------------------------------------
module chfi_ctrl
  import chfi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_LINK = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (sts.hash_done) begin
          case (sts.op)
            OP_CLEAR: begin
              if (sts.out_free) begin
                cmd.clear    = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_NONE;
                state_next   = ST_IDLE;
              end
            end
            OP_LOOKUP, OP_INSERT: begin
              if (sts.bucket_valid) begin
                cmd.rd_en  = 1'b1;
                state_next = ST_WALK;
              end else if (sts.out_free) begin
                cmd.res_load = 1'b1;
                if (sts.op == OP_INSERT) begin
                  cmd.claim_base = 1'b1;
                  cmd.res_kind   = RES_BASE;
                end else begin
                  cmd.res_kind = RES_NONE;
                end
                state_next = ST_IDLE;
              end
            end
            default: begin
              if (sts.out_free) begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_NONE;
                state_next   = ST_IDLE;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        if (sts.key_match) begin
          if (sts.out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_HIT;
            state_next   = ST_IDLE;
          end
        end else if (!sts.link_zero) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_link = 1'b1;
        end else if (sts.op == OP_LOOKUP) begin
          if (sts.out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_NONE;
            state_next   = ST_IDLE;
          end
        end else if (sts.pool_full) begin
          if (sts.out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_FULL;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.write_pool = 1'b1;
          state_next     = ST_LINK;
        end
      end
      ST_LINK: begin
        if (sts.out_free) begin
          cmd.link_tail = 1'b1;
          cmd.res_load  = 1'b1;
          cmd.res_kind  = RES_POOL;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/chfi_dp.sv
// ----------------------------------------------------------------------------
// chfi_dp
// Datapath: bucket hash, entry memories, counters and result register.
// ----------------------------------------------------------------------------
module chfi_dp
  import chfi_pkg::*;
#(
  parameter int BUCKET_COUNT = 64,
  parameter int POOL_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            op_in,
  input  logic [COORD_BITS-1:0] x_in,
  input  logic [COORD_BITS-1:0] y_in,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  found,
  output logic                  created,
  output logic [6:0]            slot,
  output logic                  full_res,
  output logic [7:0]            entry_count
);

  localparam int SLOTS     = BUCKET_COUNT + POOL_ENTRIES;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int B_W       = $clog2(BUCKET_COUNT);
  localparam int NF_W      = $clog2(POOL_ENTRIES + 1);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int H_W       = COORD_BITS + 5;
  localparam int HNEG      = 14 * (1 << (COORD_BITS - 1));
  localparam int HPOS      = 14 * ((1 << (COORD_BITS - 1)) - 1);
  localparam int OFFSET    = BUCKET_COUNT * ((HNEG + BUCKET_COUNT - 1) / BUCKET_COUNT);
  localparam int UMAX      = OFFSET + HPOS;
  localparam int U_W       = $clog2(UMAX + 1);
  localparam int REM_STEPS = 3;
  localparam int STEP_W    = $clog2(REM_STEPS + 1);
  localparam bit IS_POW2   = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
  localparam logic [U_W-1:0] RECIP = U_W'((64'd1 << U_W) / BUCKET_COUNT);
  localparam logic [U_W-1:0] BMASK = U_W'(BUCKET_COUNT - 1);

  logic [KEY_W-1:0]  key_mem  [SLOTS];
  logic [SLOT_W-1:0] link_mem [SLOTS];

  logic [1:0]              op_r;
  logic [KEY_W-1:0]        key_r;
  logic [U_W-1:0]          rem;
  logic [U_W-1:0]          quot;
  logic [STEP_W-1:0]       steps;
  logic [SLOT_W-1:0]       cur;
  logic [KEY_W-1:0]        key_rd;
  logic [SLOT_W-1:0]       link_rd;
  logic [BUCKET_COUNT-1:0] base_valid;
  logic [NF_W-1:0]         next_free;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;

  logic signed [H_W-1:0] xs;
  logic signed [H_W-1:0] ys;
  logic signed [H_W-1:0] h;
  logic [U_W-1:0]        u;
  logic [B_W-1:0]        bucket;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     new_slot;
  logic [SLOT_W-1:0]     wr_addr;
  logic                  key_we;
  logic [SLOT_W-1:0]     link_addr;
  logic [SLOT_W-1:0]     link_wd;
  logic                  link_we;
  logic [SLOT_W-1:0]     res_slot;

  // signed hash 3x + 11y shifted by a multiple of the bucket count
  always_comb begin
    xs = {{(H_W - COORD_BITS){x_in[COORD_BITS-1]}}, x_in};
    ys = {{(H_W - COORD_BITS){y_in[COORD_BITS-1]}}, y_in};
    h  = (xs <<< 1) + xs + (ys <<< 3) + (ys <<< 1) + ys + H_W'(OFFSET);
    u  = U_W'(h);
  end

  assign bucket   = rem[B_W-1:0];
  assign rd_addr  = cmd.rd_link ? link_rd : SLOT_W'(bucket);
  assign new_slot = SLOT_W'(BUCKET_COUNT) + SLOT_W'(next_free);

  always_comb begin
    key_we    = cmd.claim_base | cmd.write_pool;
    wr_addr   = cmd.claim_base ? SLOT_W'(bucket) : new_slot;
    link_we   = cmd.claim_base | cmd.write_pool | cmd.link_tail;
    link_addr = cmd.link_tail ? cur : wr_addr;
    link_wd   = cmd.link_tail ? new_slot : '0;
  end

  always_comb begin
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.claim_base | cmd.link_tail) begin
      count_next = count + CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    case (cmd.res_kind)
      RES_HIT:  res_slot = cur;
      RES_BASE: res_slot = SLOT_W'(bucket);
      RES_POOL: res_slot = new_slot;
      default:  res_slot = '0;
    endcase
  end

  always_comb begin
    sts.op           = op_r;
    sts.hash_done    = steps == '0;
    sts.bucket_valid = base_valid[bucket];
    sts.key_match    = key_rd == key_r;
    sts.link_zero    = link_rd == '0;
    sts.pool_full    = next_free >= NF_W'(POOL_ENTRIES);
    sts.out_free     = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    if (link_we) begin
      link_mem[link_addr] <= link_wd;
    end
    if (cmd.rd_en) begin
      key_rd  <= key_mem[rd_addr];
      link_rd <= link_mem[rd_addr];
      cur     <= rd_addr;
    end
  end

  // bucket remainder: a mask for a power of two, else a reciprocal
  // quotient estimate, a subtract and one correction step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_in;
      key_r <= {y_in, x_in};
      rem   <= IS_POW2 ? (u & BMASK) : u;
    end else begin
      case (steps)
        STEP_W'(3): quot <= U_W'(((2 * U_W)'(rem) * (2 * U_W)'(RECIP)) >> U_W);
        STEP_W'(2): rem  <= rem - U_W'(quot * U_W'(BUCKET_COUNT));
        STEP_W'(1): begin
          if (rem >= U_W'(BUCKET_COUNT)) begin
            rem <= rem - U_W'(BUCKET_COUNT);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.load) begin
      steps <= IS_POW2 ? '0 : STEP_W'(REM_STEPS);
    end else if (steps != '0) begin
      steps <= steps - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      base_valid <= '0;
      next_free  <= '0;
      count      <= '0;
    end else begin
      if (cmd.claim_base) begin
        base_valid[bucket] <= 1'b1;
      end
      if (cmd.link_tail) begin
        next_free <= next_free + NF_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      found       <= cmd.res_kind == RES_HIT;
      created     <= (cmd.res_kind == RES_BASE) || (cmd.res_kind == RES_POOL);
      full_res    <= cmd.res_kind == RES_FULL;
      slot        <= 7'(res_slot);
      entry_count <= 8'(count_next);
    end
  end

endmodule

FILE: design/chained_hash_find_or_insert.sv
// ----------------------------------------------------------------------------
// chained_hash_find_or_insert
// Hash map on signed 2D keys with base buckets and a chained overflow pool.
//
//   channel  dir  handshake          content
//   s_       in   s_tvalid/s_tready  tuser: operation, tdata: key_x, key_y
//   m_       out  m_tvalid/m_tready  tuser: found, created, full_res,
//                                    tdata: slot, entry_count
//
// one item at a time: accept, hash, one read per chain entry, and for a
// pool insert a pool write before the link-in
// a bucket count that is not a power of two adds remainder steps to the hash
// reset clears all entries at once; no clearing pass
// the result sits in an output register, so a stalled m_tready blocks only
// the next result, not the next accept
// ----------------------------------------------------------------------------
module chained_hash_find_or_insert
  import chfi_pkg::*;
#(
  parameter int BUCKET_COUNT = 64,
  parameter int POOL_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // key_x, key_y
  input  logic [1:0]  s_tuser,  // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // slot, entry_count, zero pad
  output logic [2:0]  m_tuser   // found, created, full_res
);

  cmd_t       cmd;
  sts_t       sts;
  logic       found;
  logic       created;
  logic       full_res;
  logic [6:0] slot;
  logic [7:0] entry_count;

  chfi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chfi_dp #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op_in       (s_tuser),
    .x_in        (s_tdata[15:0]),
    .y_in        (s_tdata[31:16]),
    .cmd         (cmd),
    .sts         (sts),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .found       (found),
    .created     (created),
    .slot        (slot),
    .full_res    (full_res),
    .entry_count (entry_count)
  );

  assign m_tdata = {1'b0, entry_count, slot};
  assign m_tuser = {full_res, created, found};

endmodule

FILE: design/chfi_checker.sv
// ----------------------------------------------------------------------------
// chfi_checker
// Port-level checks for the chained hash find-or-insert block.
// ----------------------------------------------------------------------------
module chfi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while busy");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]) && !(m_tuser[2] && (m_tuser[0] || m_tuser[1])))
    else $error("conflicting result flags");

  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tdata[6:0] == 7'd0)
    else $error("slot reported on full pool");

endmodule

bind chained_hash_find_or_insert chfi_checker u_chk (.*);

FILE: dv/chained_hash_find_or_insert_tb.sv
// ----------------------------------------------------------------------------
// chained_hash_find_or_insert_tb
// Self-checking bench for the chained hash find-or-insert block. A local
// model of the base buckets, the overflow pool and its links predicts every
// result as items are accepted. Directed cases cover misses, hits, chain
// walks, coordinate extremes, unknown codes, a table filled to capacity, a
// single maximal chain, an exhausted pool and clear. Random traffic, mostly on
// a narrow key range, then runs under several idling patterns, and one
// stretch holds the output off long enough to back the block up.
// ----------------------------------------------------------------------------
module chained_hash_find_or_insert_tb;
  import chfi_pkg::*;

  localparam int BUCKETS      = 64;
  localparam int POOL_N       = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic       found;
    logic       created;
    logic [6:0] slot;
    logic       full_res;
    logic [7:0] entry_count;
  } hash_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // key_x, key_y
  logic [1:0]  s_tuser = '0;  // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // slot, entry_count, zero pad
  logic [2:0]  m_tuser;       // found, created, full_res

  chained_hash_find_or_insert uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // model of the table
  logic        tbl_used [BUCKETS];
  logic [31:0] tbl_key  [BUCKETS];
  logic [6:0]  tbl_next [BUCKETS];
  logic [31:0] ovf_key  [POOL_N];
  logic [6:0]  ovf_next [POOL_N];
  int          ovf_fill;
  int          live_entries;

  hash_result_t awaited_results[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  logic hold_req = 1'b0;
  logic hold_armed = 1'b0;
  int   hold_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("chained_hash_find_or_insert test failed");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_count <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
    if (!hold_req) hold_armed <= 1'b0;
  end

  function automatic void clear_model();
    for (int i = 0; i < BUCKETS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_next[i] = '0;
    end
    for (int i = 0; i < POOL_N; i++) begin
      ovf_key[i]  = '0;
      ovf_next[i] = '0;
    end
    ovf_fill     = 0;
    live_entries = 0;
  endfunction

  function automatic hash_result_t predict_access(input logic [1:0] op,
                                                  input logic [15:0] x,
                                                  input logic [15:0] y);
    hash_result_t r;
    logic [31:0]  key;
    logic [31:0]  cur_key;
    int           h, b, cur, tail, steps;
    bit           hit;
    r   = '0;
    key = {y, x};
    if (op == OP_CLEAR) begin
      clear_model();
    end else if (op == OP_LOOKUP || op == OP_INSERT) begin
      h = 3 * int'($signed(x)) + 11 * int'($signed(y));
      b = h % BUCKETS;
      if (b < 0) b += BUCKETS;
      if (!tbl_used[b]) begin
        if (op == OP_INSERT) begin
          tbl_used[b] = 1'b1;
          tbl_key[b]  = key;
          tbl_next[b] = '0;
          live_entries++;
          r.created = 1'b1;
          r.slot    = 7'(b);
        end
      end else begin
        cur   = b;
        tail  = b;
        steps = 0;
        hit   = 1'b0;
        while (steps <= POOL_N) begin
          cur_key = (cur < BUCKETS) ? tbl_key[cur] : ovf_key[cur - BUCKETS];
          if (cur_key == key) begin
            hit = 1'b1;
            break;
          end
          tail = cur;
          cur  = (cur < BUCKETS) ? tbl_next[cur] : ovf_next[cur - BUCKETS];
          if (cur == 0) break;
          steps++;
        end
        if (hit) begin
          r.found = 1'b1;
          r.slot  = 7'(cur);
        end else if (op == OP_INSERT) begin
          if (ovf_fill >= POOL_N) begin
            r.full_res = 1'b1;
          end else begin
            ovf_key[ovf_fill]  = key;
            ovf_next[ovf_fill] = '0;
            if (tail < BUCKETS) tbl_next[tail] = 7'(BUCKETS + ovf_fill);
            else ovf_next[tail - BUCKETS] = 7'(BUCKETS + ovf_fill);
            r.created = 1'b1;
            r.slot    = 7'(BUCKETS + ovf_fill);
            ovf_fill++;
            live_entries++;
          end
        end
      end
    end
    r.entry_count = live_entries[7:0];
    return r;
  endfunction

  task automatic issue_access(input logic [1:0] op, input logic [15:0] x,
                              input logic [15:0] y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    awaited_results.push_back(predict_access(op, x, y));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic report_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    hash_result_t want;
    hash_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.found       = m_tuser[0];
      got.created     = m_tuser[1];
      got.full_res    = m_tuser[2];
      got.slot        = m_tdata[6:0];
      got.entry_count = m_tdata[14:7];
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        report_field("found", want.found, got.found);
        report_field("created", want.created, got.created);
        report_field("slot", want.slot, got.slot);
        report_field("full_res", want.full_res, got.full_res);
        report_field("entry_count", want.entry_count, got.entry_count);
      end
    end
  end

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    issue_access(OP_LOOKUP, 16'd0, 16'd0);    // miss on empty table
    issue_access(OP_INSERT, 16'd0, 16'd0);    // claims base entry
    issue_access(OP_INSERT, 16'd0, 16'd0);    // already present
    issue_access(OP_LOOKUP, 16'd0, 16'd0);
    issue_access(OP_INSERT, 16'd64, 16'd0);   // collides, goes to pool
    issue_access(OP_LOOKUP, 16'd64, 16'd0);
    issue_access(OP_LOOKUP, 16'd128, 16'd0);  // miss after chain walk
    issue_access(OP_INSERT, 16'h7FFF, 16'h7FFF);
    issue_access(OP_INSERT, 16'h8000, 16'h8000);
    issue_access(OP_INSERT, 16'h7FFF, 16'h8000);
    issue_access(OP_INSERT, 16'h8000, 16'h7FFF);
    issue_access(OP_LOOKUP, 16'h7FFF, 16'h7FFF);
    issue_access(OP_LOOKUP, 16'h8000, 16'h8000);
    issue_access(OP_LOOKUP, 16'h7FFF, 16'h8000);
    issue_access(OP_LOOKUP, 16'h8000, 16'h7FFF);
    issue_access(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    issue_access(OP_LOOKUP, 16'hFFFF, 16'hFFFF);
    issue_access(OP_INSERT, 16'hFFFF, 16'h0000);  // negative hash
    issue_access(OP_CLEAR, 16'hFFFF, 16'hFFFF);
    issue_access(OP_LOOKUP, 16'd0, 16'd0);
    issue_access(OP_INSERT, 16'd5, 16'hFFFB);
    drain_results();
  endtask

  // every base entry and every pool entry claimed, then one more
  task automatic test_table_full();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    issue_access(OP_CLEAR, 16'd0, 16'd0);
    for (int i = 0; i < BUCKETS; i++) issue_access(OP_INSERT, 16'(i), 16'd0);
    for (int i = 0; i < POOL_N; i++) issue_access(OP_INSERT, 16'(i + 64), 16'd0);
    issue_access(OP_INSERT, 16'd128, 16'd0);
    issue_access(OP_INSERT, 16'd3, 16'd7);
    issue_access(OP_LOOKUP, 16'd127, 16'd0);
    issue_access(OP_INSERT, 16'd5, 16'd0);
    issue_access(OP_LOOKUP, 16'd200, 16'd0);
    issue_access(OP_CLEAR, 16'd0, 16'd0);
    drain_results();
  endtask

  // one bucket holding the base entry and the whole pool
  task automatic test_long_chain();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    for (int k = 0; k <= POOL_N; k++) issue_access(OP_INSERT, 16'(64 * k), 16'd0);
    issue_access(OP_INSERT, 16'(64 * 65), 16'd0);
    issue_access(OP_INSERT, 16'd1, 16'd0);
    issue_access(OP_LOOKUP, 16'(64 * 64), 16'd0);
    issue_access(OP_LOOKUP, 16'(64 * 70), 16'd0);
    issue_access(OP_INSERT, 16'd0, 16'd0);
    issue_access(OP_CLEAR, 16'd0, 16'd0);
    drain_results();
  endtask

  // output held off while items keep coming
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    for (int i = 0; i < 16; i++) begin
      issue_access((i % 3 == 0) ? OP_LOOKUP : OP_INSERT,
                   16'($urandom_range(0, 12)) - 16'd6,
                   16'($urandom_range(0, 12)) - 16'd6);
    end
    hold_req <= 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int          roll;
    logic [1:0]  op;
    logic [15:0] x, y;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) op = OP_INSERT;
      else if (roll < 93) op = OP_LOOKUP;
      else if (roll < 95) op = OP_CLEAR;
      else op = OP_UNUSED;
      if ($urandom_range(0, 99) < 80) begin
        x = 16'($urandom_range(0, 12)) - 16'd6;
        y = 16'($urandom_range(0, 12)) - 16'd6;
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      issue_access(op, x, y);
    end
    drain_results();
  endtask

  initial begin
    clear_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_table_full();
    test_long_chain();
    test_output_backpressure();
    test_random_traffic(80, 0, 0);
    test_random_traffic(80, 85, 0);
    test_random_traffic(80, 0, 85);
    test_random_traffic(80, 32, 32);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("chained_hash_find_or_insert test passed");
    end else begin
      $display("chained_hash_find_or_insert test failed");
    end
    $finish;
  end

endmodule
